@@ hdl/aes_pkg.sv @@
// Package for the AES-128 cipher core: payload structs, mode codes, S-box tables
// and GF(2^8) helper functions. No dependencies.
package aes_pkg;

  localparam int unsigned NumRounds  = 10;
  localparam int unsigned StoreDepth = 22;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ENC  = 2'd1,
    MODE_DEC  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_KEY0 = 2'd1,
    ST_RUN  = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  typedef struct packed {
    logic signed [63:0] data_hi;
    logic signed [63:0] data_lo;
    logic               key_half;
    logic [3:0]         key_slot;
    logic [1:0]         mode;
  } req_t;

  typedef struct packed {
    logic signed [63:0] out_hi;
    logic signed [63:0] out_lo;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;   // capture input block
    logic       init_key;  // first key addition
    logic       do_round;  // apply one round
    logic       last;      // final round, no mix
    logic       decrypt;
    logic [3:0] rd_round;  // round key number to fetch
    logic       out_load;  // move state into output register
  } cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // MixColumns on one column, forward or inverse
  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] m3 [4];
    logic [31:0] r;
    for (int i = 0; i < 4; i++) begin
      a[i]  = c[8*i +: 8];
      x2[i] = xtime(a[i]);
      x4[i] = xtime(x2[i]);
      x8[i] = xtime(x4[i]);
      m3[i] = x2[i] ^ a[i];
      m9[i] = x8[i] ^ a[i];
      mb[i] = x8[i] ^ x2[i] ^ a[i];
      md[i] = x8[i] ^ x4[i] ^ a[i];
      me[i] = x8[i] ^ x4[i] ^ x2[i];
    end
    for (int j = 0; j < 4; j++) begin
      if (inv) begin
        r[8*j +: 8] = me[j] ^ mb[(j+1)%4] ^ md[(j+2)%4] ^ m9[(j+3)%4];
      end else begin
        r[8*j +: 8] = x2[j] ^ m3[(j+1)%4] ^ a[(j+2)%4] ^ a[(j+3)%4];
      end
    end
    mix_col = r;
  endfunction

endpackage

@@ hdl/aes128_block_encrypt_decrypt_core.sv @@
// Top level of the AES-128 core over an externally expanded key schedule.
// Depends on aes_pkg, aes_ctrl, aes_dp.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_req_i  (aes_pkg::req_t)
// out      output     out_valid_o / out_ready_i out_rsp_o (aes_pkg::rsp_t)
//
// A cipher request runs the initial key addition, then ten rounds through one
// round unit fed by one round-key read per cycle, then loads the output
// register. The first key read starts in the accepting cycle. The core accepts
// again in the cycle after the result is loaded. A load request with a valid
// slot writes its key half in the accepting cycle and leaves the core idle.
// Reset clears control only; round keys must be loaded before use.
// A result held while out_ready_i is low stalls the next cipher request.
module aes128_block_encrypt_decrypt_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  aes_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output aes_pkg::rsp_t out_rsp_o
);

  aes_pkg::cmd_t cmd;
  logic          key_we;

  // Write key half on load request with a valid slot
  assign key_we = in_valid_i && in_ready_o && (in_req_i.mode == aes_pkg::MODE_LOAD) &&
                  (in_req_i.key_slot <= 4'(aes_pkg::NumRounds));

  aes_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_mode_i(in_req_i.mode), .in_ready_o,
    .out_valid_i(out_valid_o), .out_ready_i, .cmd_o(cmd));

  aes_dp u_dp (
    .clk_i, .rst_ni, .req_i(in_req_i), .key_we_i(key_we), .cmd_i(cmd),
    .out_ready_i, .out_valid_o, .rsp_o(out_rsp_o));

endmodule

@@ hdl/aes_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module aes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 22
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/aes_ctrl.sv @@
// Controller for the AES-128 core: sequences key fetch and rounds per request.
// Depends on aes_pkg.
module aes_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_mode_i,
  output logic                in_ready_o,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  output aes_pkg::cmd_t       cmd_o
);

  aes_pkg::state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       dec_q, dec_d;
  logic       start;

  assign start = in_valid_i && in_ready_o &&
                 (in_mode_i == aes_pkg::MODE_ENC || in_mode_i == aes_pkg::MODE_DEC);

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dec_d   = dec_q;
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        if (start) begin
          state_d = aes_pkg::ST_KEY0;
          cnt_d   = 4'd1;
          dec_d   = (in_mode_i == aes_pkg::MODE_DEC);
        end
      end
      aes_pkg::ST_KEY0: state_d = aes_pkg::ST_RUN;
      aes_pkg::ST_RUN: begin
        if (cnt_q == 4'(aes_pkg::NumRounds)) begin
          state_d = aes_pkg::ST_DONE;
        end
        cnt_d = cnt_q + 4'd1;
      end
      aes_pkg::ST_DONE: begin
        if (!out_valid_i || out_ready_i) begin
          state_d = aes_pkg::ST_IDLE;
        end
      end
      default: state_d = aes_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.decrypt  = dec_q;
    in_ready_o     = (state_q == aes_pkg::ST_IDLE);
    unique case (state_q)
      aes_pkg::ST_IDLE: begin
        cmd_o.load_in  = start;
        cmd_o.decrypt  = (in_mode_i == aes_pkg::MODE_DEC);
        cmd_o.rd_round = (in_mode_i == aes_pkg::MODE_DEC) ? 4'(aes_pkg::NumRounds) : 4'd0;
      end
      aes_pkg::ST_KEY0: begin
        cmd_o.init_key = 1'b1;
        cmd_o.rd_round = dec_q ? 4'(aes_pkg::NumRounds) - cnt_q : cnt_q;
      end
      aes_pkg::ST_RUN: begin
        cmd_o.do_round = 1'b1;
        cmd_o.last     = (cnt_q == 4'(aes_pkg::NumRounds));
        cmd_o.rd_round = dec_q ? 4'(aes_pkg::NumRounds) - cnt_q - 4'd1 : cnt_q + 4'd1;
      end
      aes_pkg::ST_DONE: begin
        cmd_o.out_load = (!out_valid_i || out_ready_i);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_pkg::ST_IDLE;
      cnt_q   <= '0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dec_q   <= dec_d;
    end
  end

`ifndef ASSERT_OFF
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == aes_pkg::ST_RUN |-> cnt_q >= 4'd1 && cnt_q <= 4'(aes_pkg::NumRounds))
    else $error("round count out of range");
  a_key0_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == aes_pkg::ST_KEY0 |=> state_q == aes_pkg::ST_RUN)
    else $error("key addition not followed by rounds");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> state_q == aes_pkg::ST_KEY0)
    else $error("start missed");
`endif

endmodule

@@ hdl/aes_dp.sv @@
// Datapath for the AES-128 core: key store, state register, round logic, output.
// Depends on aes_pkg and aes_ram.
module aes_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  aes_pkg::req_t req_i,
  input  logic          key_we_i,
  input  aes_pkg::cmd_t cmd_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output aes_pkg::rsp_t rsp_o
);

  logic [127:0] st_q, st_d;
  logic [127:0] rkey, rkey_m, sb, sr, mx, rnd;
  logic [63:0]  rd_lo, rd_hi;
  logic         out_valid_q;

  // Two banks, one for each key half, so a round key comes in one read
  aes_ram #(.Width(64), .Depth(aes_pkg::NumRounds + 1)) u_ram_lo (
    .clk_i, .we_i(key_we_i && !req_i.key_half), .waddr_i(req_i.key_slot),
    .wdata_i(req_i.data_lo), .raddr_i(cmd_i.rd_round), .rdata_o(rd_lo));
  aes_ram #(.Width(64), .Depth(aes_pkg::NumRounds + 1)) u_ram_hi (
    .clk_i, .we_i(key_we_i && req_i.key_half), .waddr_i(req_i.key_slot),
    .wdata_i(req_i.data_lo), .raddr_i(cmd_i.rd_round), .rdata_o(rd_hi));

  assign rkey = {rd_hi, rd_lo};

  // Round transform: shift rows, substitute, mix, key addition
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (cmd_i.decrypt) begin
          sr[8*(r + 4*((c + r) % 4)) +: 8] = st_q[8*(r + 4*c) +: 8];
        end else begin
          sr[8*(r + 4*c) +: 8] = st_q[8*(r + 4*((c + r) % 4)) +: 8];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[8*i +: 8] = cmd_i.decrypt ? aes_pkg::INV_SBOX[sr[8*i +: 8]]
                                   : aes_pkg::SBOX[sr[8*i +: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      mx[32*c +: 32]     = aes_pkg::mix_col(sb[32*c +: 32], cmd_i.decrypt);
      rkey_m[32*c +: 32] = aes_pkg::mix_col(rkey[32*c +: 32], 1'b1);
    end
    if (cmd_i.last) begin
      rnd = sb ^ rkey;
    end else if (cmd_i.decrypt) begin
      rnd = mx ^ rkey_m;
    end else begin
      rnd = mx ^ rkey;
    end
  end

  // State register
  always_comb begin
    st_d = st_q;
    priority if (cmd_i.load_in) begin
      st_d = {req_i.data_hi, req_i.data_lo};
    end else if (cmd_i.init_key) begin
      st_d = st_q ^ rkey;
    end else if (cmd_i.do_round) begin
      st_d = rnd;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (cmd_i.out_load) begin
      rsp_o <= st_q;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_load_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.load_in, cmd_i.init_key, cmd_i.do_round, cmd_i.out_load}))
    else $error("conflicting datapath commands");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd_i.out_load)
    else $error("pending result overwritten");
  a_out_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result not flagged");
`endif

endmodule
